>>> src/torq_pkg.sv
// ----------------------------------------------------------------------------
// torq_pkg: shared types and helpers for the timestamp-ordered request queue
// Entry layout, request codes and the ordering compare used by every cell.
// ----------------------------------------------------------------------------
package torq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int RANK_W = 8;
  localparam int TS_W   = 32;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
    logic [TS_W-1:0]   ts;
  } entry_t;

  // per-cycle command broadcast to all cells
  typedef struct packed {
    logic              ins;   // insert the request entry
    logic              pop;   // head matched on remove: shift forward
    logic [RANK_W-1:0] rank;
    logic [TS_W-1:0]   ts;
  } cell_ctl_t;

  localparam entry_t ENTRY_EMPTY = '{vld: 1'b0, rank: '0, ts: '0};

  // true when entry e orders after (rank, ts): later time, or same time and higher id
  function automatic logic ent_after(entry_t e, logic [RANK_W-1:0] rank,
                                     logic [TS_W-1:0] ts);
    ent_after = (e.ts > ts) || ((e.ts == ts) && (e.rank > rank));
  endfunction

endpackage

>>> src/timestamp_ordered_request_queue.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue: sorted request queue built as a cell chain
// QUEUE_DEPTH slots kept sorted by (timestamp, id); insert, conditional pop
// of the head, and head check. Every word returned carries the new head.
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH identical cells, slot 0 being the head.
// Each request word is resolved as it is accepted: every cell compares its
// entry against the request in parallel and, in the same clock, either keeps
// its entry, takes the request, or takes a neighbor's entry. Throughput is one
// request word per cycle; the result word appears the cycle after acceptance
// and is held in an output register, so a new request is accepted whenever the
// result register is empty or being drained. The critical path is one 40-bit
// compare per cell plus the left-neighbor select. Slots start empty after
// reset with no clearing pass. A full queue drops its last entry on an insert
// that lands ahead of it, or drops the request if it orders after everything.
// Request type 3 is a no-op returning hit 0.
module timestamp_ordered_request_queue #(
  parameter int QUEUE_DEPTH = torq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [torq_pkg::RANK_W-1:0] in_req_rank,
  input  logic [torq_pkg::TS_W-1:0]   in_req_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic                        out_head_valid,
  output logic [torq_pkg::RANK_W-1:0] out_head_rank,
  output logic [torq_pkg::TS_W-1:0]   out_head_time
);
  import torq_pkg::*;

  logic      in_fire;
  logic      head_match;
  logic      hit;
  cell_ctl_t ctl;

  entry_t                 cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH-1:0] vld_vec;

  logic out_valid_r, out_valid_nxt;
  logic out_hit_r,   out_hit_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // head compare for remove / check
  assign head_match = cell_ent[0].vld && (cell_ent[0].rank == in_req_rank) &&
                      (cell_ent[0].ts == in_req_time);

  always_comb begin
    hit = 1'b0;
    if (in_req_type inside {REQ_REMOVE, REQ_CHECK}) begin
      hit = head_match;
    end
  end

  assign ctl.ins  = in_fire && (in_req_type == REQ_INSERT);
  assign ctl.pop  = in_fire && (in_req_type == REQ_REMOVE) && head_match;
  assign ctl.rank = in_req_rank;
  assign ctl.ts   = in_req_time;

  // ---- cell chain ---------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_gt;

    if (i == 0) begin : g_head
      assign prev_ent = ENTRY_EMPTY;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = cell_ent[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign next_ent = ENTRY_EMPTY;   // vacated slot on pop
    end else begin : g_body
      assign next_ent = cell_ent[i+1];
    end

    torq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ent (prev_ent),
      .prev_gt  (prev_gt),
      .next_ent (next_ent),
      .ent      (cell_ent[i]),
      .gt       (cell_gt[i])
    );

    assign vld_vec[i] = cell_ent[i].vld;
  end

  // ---- result register ----------------------------------------------------
  // Head fields come straight from slot 0: it only changes on an accepted
  // word, which can't happen while a result is stalled.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = hit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_head_valid = cell_ent[0].vld;
  assign out_head_rank  = cell_ent[0].vld ? cell_ent[0].rank : '0;
  assign out_head_time  = cell_ent[0].vld ? cell_ent[0].ts : '0;

`ifndef ASSERT_OFF
  // entries stay packed at the front and sorted
  for (genvar k = 0; k < QUEUE_DEPTH-1; k++) begin : g_chk_order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
      vld_vec[k+1] |-> (vld_vec[k] && !ent_after(cell_ent[k], cell_ent[k+1].rank,
                                                 cell_ent[k+1].ts)))
      else $error("queue entries out of order at slot %0d", k);
  end

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> ($countones(vld_vec) == $past($countones(vld_vec)) - 1))
    else $error("pop did not remove exactly one entry");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ins && !vld_vec[QUEUE_DEPTH-1]) |=>
      ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
    else $error("insert into non-full queue did not add one entry");

  a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ins && vld_vec[QUEUE_DEPTH-1]) |=> vld_vec[QUEUE_DEPTH-1])
    else $error("insert into full queue lost the full state");
`endif

endmodule

>>> src/torq_cell.sv
// ----------------------------------------------------------------------------
// torq_cell: one queue slot
// Holds one entry; on insert takes the new entry or its left neighbor's,
// on pop takes its right neighbor's. Reports whether it orders after the
// incoming entry so the next cell can tell where the insert lands.
// ----------------------------------------------------------------------------
module torq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  torq_pkg::cell_ctl_t ctl,
  input  torq_pkg::entry_t   prev_ent,
  input  logic               prev_gt,
  input  torq_pkg::entry_t   next_ent,
  output torq_pkg::entry_t   ent,
  output logic               gt
);
  import torq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // empty slots count as "after" so the insert lands in the first free one
  assign gt = !ent_r.vld || ent_after(ent_r, ctl.rank, ctl.ts);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (prev_gt) begin
        ent_nxt = prev_ent;          // shift back behind the new entry
      end else if (gt) begin
        ent_nxt.vld  = 1'b1;         // insert point
        ent_nxt.rank = ctl.rank;
        ent_nxt.ts   = ctl.ts;
      end
    end else if (ctl.pop) begin
      ent_nxt = next_ent;
    end
  end

  // only the valid bit is reset; id and time are masked while it is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.rank <= ent_nxt.rank;
    ent_r.ts   <= ent_nxt.ts;
  end

  assign ent = ent_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for timestamp_ordered_request_queue
// Sends insert, remove, check and unused request words through the valid/ready
// port and keeps its own sorted copy of the slots. Every result word is
// checked field by field against that copy or a hand-typed result. The run
// covers idle, stall and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
  import torq_pkg::*;

  localparam int         DEPTH       = QUEUE_DEPTH_DEF;
  localparam logic [1:0] REQ_NOP     = 2'd3;    // unused selector, must be a no-op
  localparam int         HOLD_CYCLES = 200;     // long receiver hold-off
  localparam int         CYCLE_LIMIT = 200000;  // watchdog limit, well above a normal run
  localparam int         DIR_ROWS    = 14;

  // one result word, laid out like the output ports
  typedef struct packed {
    logic              hit;
    logic              head_valid;
    logic [RANK_W-1:0] head_rank;
    logic [TS_W-1:0]   head_time;
  } head_report_t;

  // directed row; when pinned, want is typed in by hand and used as is
  typedef struct packed {
    logic [1:0]        kind;
    logic [RANK_W-1:0] rank;
    logic [TS_W-1:0]   ts;
    logic              pinned;
    head_report_t      want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [RANK_W-1:0] in_req_rank;
  logic [TS_W-1:0]   in_req_time;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic              out_head_valid;
  logic [RANK_W-1:0] out_head_rank;
  logic [TS_W-1:0]   out_head_time;

  // local copy of the slot array, slot 0 is the head
  logic [RANK_W-1:0] q_rank [DEPTH];
  logic [TS_W-1:0]   q_time [DEPTH];
  logic              q_vld  [DEPTH];

  head_report_t expected_heads[$];
  dir_row_t     dir_rows [DIR_ROWS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;

  int err_count    = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int inserts      = 0;
  int pops         = 0;
  int full_inserts = 0;
  int cycle_count  = 0;

  timestamp_ordered_request_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_req_rank   (in_req_rank),
    .in_req_time   (in_req_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_head_valid(out_head_valid),
    .out_head_rank (out_head_rank),
    .out_head_time (out_head_time)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor: applies one request word to the local slot copy and returns
  // the result word it should produce. Ordering is by time, then by id; an
  // equal entry lands behind the one already queued.
  function automatic head_report_t step_sorted_queue(input logic [1:0] kind,
                                                     input logic [RANK_W-1:0] rank,
                                                     input logic [TS_W-1:0] ts);
    head_report_t r;
    logic         placed;
    logic         match;
    int           i;
    int           j;
    r      = '0;
    placed = 1'b0;
    match  = q_vld[0] && (q_rank[0] == rank) && (q_time[0] == ts);
    case (kind)
      REQ_INSERT: begin
        inserts++;
        if (q_vld[DEPTH-1]) full_inserts++;
        // first empty slot, or ahead of the first entry that orders after us;
        // when full and we order after everything, nothing is placed (dropped)
        for (i = 0; i < DEPTH; i++) begin
          if (!placed && (!q_vld[i] || (q_time[i] > ts) ||
                          ((q_time[i] == ts) && (q_rank[i] > rank)))) begin
            if (q_vld[i]) begin
              // shift the tail back one slot; the last entry falls off
              for (j = DEPTH - 1; j > i; j--) begin
                q_rank[j] = q_rank[j-1];
                q_time[j] = q_time[j-1];
                q_vld[j]  = q_vld[j-1];
              end
            end
            q_rank[i] = rank;
            q_time[i] = ts;
            q_vld[i]  = 1'b1;
            placed    = 1'b1;
          end
        end
      end
      REQ_REMOVE: begin
        r.hit = match;
        if (match) begin
          pops++;
          for (i = 0; i < DEPTH - 1; i++) begin
            q_rank[i] = q_rank[i+1];
            q_time[i] = q_time[i+1];
            q_vld[i]  = q_vld[i+1];
          end
          // vacated slot is cleared
          q_rank[DEPTH-1] = '0;
          q_time[DEPTH-1] = '0;
          q_vld[DEPTH-1]  = 1'b0;
        end
      end
      REQ_CHECK: r.hit = match;
      default: ;  // unused selector: no change, hit stays 0
    endcase
    r.head_valid = q_vld[0];
    r.head_rank  = q_vld[0] ? q_rank[0] : '0;
    r.head_time  = q_vld[0] ? q_time[0] : '0;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns  mismatch on result word %0d, %s: got %0h, want %0h",
             $time, results_seen, what, got, want);
    err_count++;
  endtask

  // Offer one request word. Inputs move only at the falling edge; acceptance
  // is sampled at the rising edge. Valid stays high into the next word when
  // no idle cycle is rolled, so it is never dropped and raised in one step.
  task automatic send_req(input logic [1:0] kind, input logic [RANK_W-1:0] rank,
                          input logic [TS_W-1:0] ts, input logic pinned,
                          input head_report_t want);
    head_report_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_req_rank <= rank;
    in_req_time <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: predict in acceptance order
    predicted = step_sorted_queue(kind, rank, ts);
    expected_heads.push_back(pinned ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // Random request word. Timestamps and ids are often drawn from tiny ranges
  // so ties on time and on id are common. Removes and checks mostly target
  // the current head so pops actually happen; the rest are misses or
  // near misses (right time, random id).
  task automatic send_random(input int ins_pct);
    logic [1:0]        kind;
    logic [RANK_W-1:0] rank;
    logic [TS_W-1:0]   ts;
    int                roll;
    roll = $urandom_range(99);
    if (roll < ins_pct) kind = REQ_INSERT;
    else if (roll < ins_pct + (100 - ins_pct) * 2 / 3) kind = REQ_REMOVE;
    else if (roll < 96) kind = REQ_CHECK;
    else kind = REQ_NOP;
    case ($urandom_range(3))
      0, 1:    ts = TS_W'($urandom_range(15));
      2:       ts = $urandom();
      default: ts = 32'hFFFF_FFF0 | TS_W'($urandom_range(15));
    endcase
    if ($urandom_range(1) != 0) rank = RANK_W'($urandom_range(3));
    else rank = RANK_W'($urandom_range(255));
    if (kind != REQ_INSERT && q_vld[0]) begin
      case ($urandom_range(9))
        0: ;                      // plain random miss
        1: ts = q_time[0];        // near miss: head time, random id
        default: begin
          rank = q_rank[0];
          ts   = q_time[0];
        end
      endcase
    end
    send_req(kind, rank, ts, 1'b0, '0);
  endtask

  // Sender pause: drop valid and wait until every result word is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_heads.size() != 0);
  endtask

  // One random phase; the insert bias flips every 40 words so the queue
  // swings between empty and full.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int words);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < words; n++) send_random(((n / 40) % 2 != 0) ? 30 : 75);
    wait_drained();
  endtask

  // Receiver: random stalls per phase; on request, one long hold-off counted
  // here so the output register stays full and the input stalls behind it.
  always begin
    @(negedge clk);
    if (hold_pending) begin
      hold_pending = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result check against the oldest pending word
  always @(posedge clk) begin : result_check
    head_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_heads.size() == 0) begin
        flag_mismatch("word with nothing pending", 32'(out_head_time), 32'h0);
      end else begin
        want = expected_heads.pop_front();
        if (out_hit !== want.hit)
          flag_mismatch("hit", 32'(out_hit), 32'(want.hit));
        if (out_head_valid !== want.head_valid)
          flag_mismatch("head_valid", 32'(out_head_valid), 32'(want.head_valid));
        if (out_head_rank !== want.head_rank)
          flag_mismatch("head_rank", 32'(out_head_rank), 32'(want.head_rank));
        if (out_head_time !== want.head_time)
          flag_mismatch("head_time", out_head_time, want.head_time);
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d words pending",
               expected_heads.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int k;
    int r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_INSERT;
    in_req_rank = '0;
    in_req_time = '0;
    for (k = 0; k < DEPTH; k++) begin
      q_rank[k] = '0;
      q_time[k] = '0;
      q_vld[k]  = 1'b0;
    end

    // Directed words. Pinned rows carry a hand-typed result; the rest go
    // through the predictor.
    dir_rows = '{
      // empty queue: check, remove and unused selector all miss
      '{REQ_CHECK,  8'h00, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 8'h00, 32'h0}},
      '{REQ_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'h00, 32'h0}},
      '{REQ_NOP,    8'hFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'h00, 32'h0}},
      // field extremes: max entry first, then min entry takes the head
      '{REQ_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 8'hFF, 32'hFFFF_FFFF}},
      '{REQ_INSERT, 8'h00, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 8'h00, 32'h0}},
      '{REQ_CHECK,  8'h00, 32'h0000_0000, 1'b1, '{1'b1, 1'b1, 8'h00, 32'h0}},
      // equal entry queues behind its twin
      '{REQ_INSERT, 8'h00, 32'h0000_0000, 1'b0, '0},
      // same time, lower id must sort first
      '{REQ_INSERT, 8'h80, 32'h8000_0000, 1'b0, '0},
      '{REQ_INSERT, 8'h7F, 32'h8000_0000, 1'b0, '0},
      '{REQ_REMOVE, 8'h00, 32'h0000_0000, 1'b0, '0},
      '{REQ_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},  // not the head
      '{REQ_REMOVE, 8'h00, 32'h0000_0000, 1'b0, '0},  // second twin
      '{REQ_CHECK,  8'h7F, 32'h8000_0001, 1'b0, '0},  // time off by one
      '{REQ_NOP,    8'h7F, 32'h8000_0000, 1'b0, '0}   // matches head, still no hit
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++)
      send_req(dir_rows[r].kind, dir_rows[r].rank, dir_rows[r].ts,
               dir_rows[r].pinned, dir_rows[r].want);

    // fill up: three queued, thirteen more land ahead of the 0x80000000 pair
    for (k = 0; k < DEPTH - 3; k++)
      send_req(REQ_INSERT, RANK_W'(k + 1), TS_W'(32'h100 + k), 1'b0, '0);
    // full queue: equal to the last entry orders after all, so it is dropped
    send_req(REQ_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0);
    // full queue: new head, last entry falls off
    send_req(REQ_INSERT, 8'h01, 32'h0000_0001, 1'b0, '0);
    wait_drained();

    // random phases: back to back, sender idle, receiver stall, both
    run_phase(0,  0,  320);
    run_phase(54, 0,  320);
    run_phase(0,  54, 320);
    run_phase(8,  8,  320);

    // back-pressure: receiver holds off while the sender keeps offering
    hold_pending = 1'b1;
    run_phase(0, 0, 60);

    // let any stray word show up
    repeat (8) @(negedge clk);

    $display("Sent %0d request words: %0d inserts (%0d into a full queue), %0d head pops",
             words_sent, inserts, full_inserts, pops);
    $display("Checked %0d result words over idle, stall and back-pressure phases",
             results_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
